FILE: design/sisr_pkg.sv
package sisr_pkg;

  // Default ring size and switch-code behavior.
  localparam int unsigned RING_DEPTH = 128;
  localparam logic [7:0] TOGGLE_BYTE_RESET = 8'd1;
  // Count of swallowed switch codes at which the next one toggles routing.
  localparam logic [1:0] REPEAT_LAST = 2'd2;

  // Input command codes.
  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_KEY     = 3'd0,
    EV_QUEUED  = 3'd1,
    EV_DROPPED = 3'd2,
    EV_TOGGLE  = 3'd3,
    EV_READ    = 3'd4,
    EV_EMPTY   = 3'd5
  } event_e;

  // One result as it travels from the sequencer to the output register.
  typedef struct packed {
    event_e     ev;
    logic [7:0] data;
    logic       use_ram;
    logic       route;
    logic [7:0] fill;
    logic       last;
  } res_t;

endpackage

FILE: design/sisr_ram.sv
module sisr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/sisr_step.sv
module sisr_step import sisr_pkg::*; #(
  parameter int unsigned RingDepth = RING_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [7:0]                   rx_byte_i,
  input  logic [7:0]                   toggle_byte_i,
  input  logic                         res_ready_i,
  output logic                         res_valid_o,
  output res_t                         res_o,
  output logic                         ram_we_o,
  output logic [$clog2(RingDepth)-1:0] ram_waddr_o,
  output logic [7:0]                   ram_wdata_o,
  output logic                         ram_re_o,
  output logic [$clog2(RingDepth)-1:0] ram_raddr_o
);

  localparam int unsigned IW = $clog2(RingDepth);
  localparam int unsigned FW = $clog2(RingDepth + 1);
  localparam logic [IW-1:0] LastIdx = IW'(RingDepth - 1);
  localparam logic [FW-1:0] FullLvl = FW'(RingDepth);

  // Input item register.
  logic       item_valid_q, item_valid_d;
  logic       cmd_q;
  logic [7:0] byte_q;

  // Routing and ring state.
  logic          route_hyp_q, route_hyp_d;
  logic [1:0]    pend_q, pend_d;
  logic [IW-1:0] wptr_q, wptr_d;
  logic [IW-1:0] rptr_q, rptr_d;
  logic [FW-1:0] fill_q, fill_d;

  logic          emit, last, fire, accept, use_ram;
  logic          wr_en, rd_en;
  logic          is_switch;
  event_e        ev;
  logic [7:0]    data;
  logic [FW+7:0] fill_ext;

  assign is_switch = (toggle_byte_i != 8'd0) && (byte_q == toggle_byte_i);

  // One result, or one swallowed switch code, per cycle for the held item; a result waits while the output stalls.
  always_comb begin
    logic [7:0] rb;
    rb          = byte_q;
    emit        = 1'b0;
    last        = 1'b1;
    ev          = EV_KEY;
    data        = 8'd0;
    use_ram     = 1'b0;
    route_hyp_d = route_hyp_q;
    pend_d      = pend_q;
    wptr_d      = wptr_q;
    rptr_d      = rptr_q;
    fill_d      = fill_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    if (cmd_q == CMD_READ) begin
      emit = 1'b1;
      if (fill_q == '0) begin
        ev = EV_EMPTY;
      end else begin
        ev      = EV_READ;
        use_ram = 1'b1;
        rd_en   = 1'b1;
        rptr_d  = (rptr_q == LastIdx) ? '0 : rptr_q + IW'(1);
        fill_d  = fill_q - FW'(1);
      end
    end else if (is_switch) begin
      if (pend_q == REPEAT_LAST) begin
        emit        = 1'b1;
        ev          = EV_TOGGLE;
        pend_d      = 2'd0;
        route_hyp_d = !route_hyp_q;
      end else begin
        pend_d = pend_q + 2'd1;
      end
    end else begin
      emit = 1'b1;
      // Pending switch codes replay first, one per cycle while results are accepted.
      if (pend_q != 2'd0) begin
        rb     = toggle_byte_i;
        pend_d = pend_q - 2'd1;
        last   = 1'b0;
      end
      data = rb;
      if (route_hyp_q) begin
        ev = EV_KEY;
      end else if (fill_q != FullLvl) begin
        ev     = EV_QUEUED;
        wr_en  = 1'b1;
        wptr_d = (wptr_q == LastIdx) ? '0 : wptr_q + IW'(1);
        fill_d = fill_q + FW'(1);
      end else begin
        ev = EV_DROPPED;
      end
    end
  end

  assign fire         = item_valid_q && (!emit || res_ready_i);
  assign in_stall_o   = item_valid_q && !(fire && last);
  assign accept       = in_valid_i && !in_stall_o;
  assign item_valid_d = accept ? 1'b1 : ((fire && last) ? 1'b0 : item_valid_q);

  // RAM requests are qualified by the step actually advancing.
  assign ram_we_o    = wr_en && fire;
  assign ram_re_o    = rd_en && fire;
  assign ram_waddr_o = wptr_q;
  assign ram_wdata_o = data;
  assign ram_raddr_o = rptr_q;

  // Result toward the output register.
  assign fill_ext      = {8'd0, fill_d};
  assign res_valid_o   = item_valid_q && emit;
  assign res_o.ev      = ev;
  assign res_o.data    = data;
  assign res_o.use_ram = use_ram;
  assign res_o.route   = !route_hyp_d;
  assign res_o.fill    = fill_ext[7:0];
  assign res_o.last    = last;

  // Control and pointer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      route_hyp_q  <= 1'b1;
      pend_q       <= 2'd0;
      wptr_q       <= '0;
      rptr_q       <= '0;
      fill_q       <= '0;
    end else begin
      item_valid_q <= item_valid_d;
      if (fire) begin
        route_hyp_q <= route_hyp_d;
        pend_q      <= pend_d;
        wptr_q      <= wptr_d;
        rptr_q      <= rptr_d;
        fill_q      <= fill_d;
      end
    end
  end

  // Item payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      byte_q <= rx_byte_i;
    end
  end

endmodule

FILE: design/sisr_out.sv
module sisr_out import sisr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       res_valid_i,
  input  res_t       res_i,
  output logic       res_ready_o,
  input  logic [7:0] ram_rdata_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output res_t       res_o
);

  logic valid_q, valid_d;
  res_t res_q;
  logic load;

  // The register takes a new result when empty or when its transfer completes.
  assign res_ready_o = !valid_q || !out_stall_i;
  assign load        = res_valid_i && res_ready_o;
  assign valid_d     = load ? 1'b1 : (res_ready_o ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  // Read data arrives from the RAM's output register in the same cycle.
  always_comb begin
    res_o = res_q;
    if (res_q.use_ram) begin
      res_o.data = ram_rdata_i;
    end
  end

  assign out_valid_o = valid_q;

endmodule

FILE: design/serial_input_switch_and_rx_ring.sv
// A result passes through the input item register and then the output register;
// later results of the same item follow one per cycle unless the output stalls.
// A read gives one result and a switch byte at most one; a received byte gives
// one result, or up to three with replayed switch codes.
// Reset selects hypervisor routing, clears pointers and the pending count and
// loads switch code 1; ring contents are not cleared.
module serial_input_switch_and_rx_ring import sisr_pkg::*; #(
  parameter int unsigned RingDepth = RING_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] rx_byte_i,
  input  logic       switch_char_code_we_i,
  input  logic [7:0] switch_char_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] event_res_o,
  output logic [7:0] data_byte_o,
  output logic       routing_to_guest_o,
  output logic [7:0] fill_level_o,
  output logic       last_o
);

  localparam int unsigned IW = $clog2(RingDepth);

  logic [7:0]    toggle_byte_q;
  logic          res_valid, res_ready;
  res_t          res, res_out;
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // Switch code register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      toggle_byte_q <= TOGGLE_BYTE_RESET;
    end else if (switch_char_code_we_i) begin
      toggle_byte_q <= switch_char_code_i;
    end
  end

  sisr_step #(
    .RingDepth(RingDepth)
  ) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .rx_byte_i    (rx_byte_i),
    .toggle_byte_i(toggle_byte_q),
    .res_ready_i  (res_ready),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr)
  );

  sisr_ram #(
    .Width(8),
    .Depth(RingDepth)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  sisr_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .res_ready_o(res_ready),
    .ram_rdata_i(ram_rdata),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res_out)
  );

  assign event_res_o        = res_out.ev;
  assign data_byte_o        = res_out.data;
  assign routing_to_guest_o = res_out.route;
  assign fill_level_o       = res_out.fill;
  assign last_o             = res_out.last;

`ifndef NO_ASSERTIONS
  // An empty read reports an empty ring and no data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_res_o == EV_EMPTY) |-> (fill_level_o == 8'd0 && data_byte_o == 8'd0))
    else $error("empty read with nonzero fill or data");

  // A routing toggle is always the only result of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_res_o == EV_TOGGLE) |-> last_o)
    else $error("toggle result not marked last");

  // Ring events happen only in guest routing, key events only in hypervisor routing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_res_o == EV_QUEUED || event_res_o == EV_DROPPED))
      |-> routing_to_guest_o)
    else $error("ring event while routed to hypervisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_res_o == EV_KEY) |-> !routing_to_guest_o)
    else $error("key handler event while routed to guest");
`endif

endmodule
